### hdl/dsl_pkg.sv
`timescale 1ns / 1ps

package dsl_pkg;

    // default store sizes
    localparam int IN_MAX_DEF  = 64;
    localparam int OUT_MAX_DEF = 64;

    // item modes
    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_FEED   = 2'd2;

    // register map
    localparam logic REG_INPUT_COUNT  = 1'b0;
    localparam logic REG_OUTPUT_COUNT = 1'b1;
    localparam logic [6:0] COUNT_RESET = 7'd64;

    // e^(-1/16) in q0.32
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] value;
        logic               last_element;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  neuron;
        logic [15:0] activation;
        logic        last_output;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic bias_rd;
        logic mac_rd;
        logic sat_en;
        logic emit;
        logic last;
    } dsl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dsl_stat_t;

    // sigmoid over [-8,8) in 1/16 bins, q0.16; evaluated at elaboration only
    function automatic logic [255:0][15:0] build_sigmoid();
        logic [255:0][15:0] t;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] s;
        t = '0;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++)
        begin
            den = (64'd1 << 32) + p;
            num = (64'd1 << 48) + (den >> 1);
            rem = '0;
            s   = '0;
            // restoring long division, one quotient bit per step
            for (int i = 49; i >= 0; i--)
            begin
                rem = {rem[62:0], num[i]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    s[i] = 1'b1;
                end
            end
            if (s > 64'd65536)
            begin
                s = 64'd65536;
            end
            if (k < 128)
            begin
                t[128 + k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
            end
            if (k > 0)
            begin
                t[128 - k] = 16'(64'd65536 - s);
            end
            p = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam logic [255:0][15:0] SIG_TABLE = build_sigmoid();

endpackage

### hdl/dsl_ctrl.sv
`timescale 1ns / 1ps

module dsl_ctrl #(
    parameter int IN_MAX  = 64,
    parameter int OUT_MAX = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  dsl_pkg::in_item_t                           in_item,
    input  logic [$clog2(IN_MAX + 1) - 1:0]             n_in,
    input  logic [$clog2(OUT_MAX + 1) - 1:0]            n_out,
    input  dsl_pkg::dsl_stat_t                          stat,
    output dsl_pkg::dsl_cmd_t                           cmd,
    output logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1) - 1:0]   col,
    output logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1) - 1:0] row,
    output logic                                        in_stall
);
    import dsl_pkg::*;

    localparam int CW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int RW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int CNTW = $clog2(IN_MAX + 1);
    localparam int NOW  = $clog2(OUT_MAX + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BIAS  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          drain_reg, drain_next;
    logic          accept;
    logic          col_last;
    logic          row_last;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign col_last = (col_reg == CW'(n_in - CNTW'(1)));
    assign row_last = (row_reg == RW'(n_out - NOW'(1)));
    assign col      = col_reg;
    assign row      = row_reg;

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        drain_next  = drain_reg;
        cmd         = '0;
        cmd.accept  = accept;
        cmd.last    = row_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.mode == MODE_FEED && in_item.last_element)
                begin
                    row_next   = '0;
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                cmd.bias_rd = 1'b1;
                col_next    = '0;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_rd = 1'b1;
                col_next   = col_reg + CW'(1);
                if (col_last)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // read and multiply stages still in flight
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                cmd.sat_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_BIAS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

endmodule

### hdl/dsl_datapath.sv
`timescale 1ns / 1ps

module dsl_datapath #(
    parameter int IN_MAX  = 64,
    parameter int OUT_MAX = 64
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  dsl_pkg::in_item_t                                  in_item,
    input  dsl_pkg::dsl_cmd_t                                  cmd,
    input  logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1) - 1:0]   col,
    input  logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1) - 1:0] row,
    output dsl_pkg::dsl_stat_t                                 stat,
    output logic                                               out_valid,
    input  logic                                               out_stall,
    output dsl_pkg::out_item_t                                 out_item
);
    import dsl_pkg::*;

    localparam int CW     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int RW     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int WDEPTH = 2 ** (RW + CW);
    localparam int ACC_W  = 33 + CW;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(134217727);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [15:0] w_mem [WDEPTH];
    logic signed [15:0] b_mem [2 ** RW];
    logic signed [15:0] x_mem [2 ** CW];

    logic [RW-1:0] wr_row;
    logic [CW-1:0] wr_col;
    logic          row_ok;
    logic          col_ok;

    logic signed [15:0]      w_q, x_q, b_q;
    logic                    mac_v1_reg, bias_v1_reg, prod_v_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] sat;
    logic [7:0]              idx_reg;
    logic [RW-1:0]           row_emit;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_item_reg;

    assign wr_row = RW'(in_item.row);
    assign wr_col = CW'(in_item.col);
    assign row_ok = (32'(in_item.row) < OUT_MAX);
    assign col_ok = (32'(in_item.col) < IN_MAX);

    // stores: written by accepted items, read by the compute sequence
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_item.mode == MODE_WEIGHT && row_ok && col_ok)
        begin
            w_mem[{wr_row, wr_col}] <= in_item.value;
        end
        if (cmd.mac_rd)
        begin
            w_q <= w_mem[{row, col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_item.mode == MODE_BIAS && row_ok)
        begin
            b_mem[wr_row] <= in_item.value;
        end
        if (cmd.bias_rd)
        begin
            b_q <= b_mem[row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_item.mode == MODE_FEED && col_ok)
        begin
            x_mem[wr_col] <= in_item.value;
        end
        if (cmd.mac_rd)
        begin
            x_q <= x_mem[col];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= w_q * x_q;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (bias_v1_reg)
        begin
            acc_next = ACC_W'(b_q) <<< 12;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // saturate to [-8,8) in q4.24, bin index is the top bits offset by 8
    always_comb
    begin
        sat = acc_reg;
        if (acc_reg > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (acc_reg < SAT_LO)
        begin
            sat = SAT_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sat_en)
        begin
            idx_reg  <= {~sat[27], sat[26:20]};
            row_emit <= row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v1_reg  <= 1'b0;
            bias_v1_reg <= 1'b0;
            prod_v_reg  <= 1'b0;
        end
        else
        begin
            mac_v1_reg  <= cmd.mac_rd;
            bias_v1_reg <= cmd.bias_rd;
            prod_v_reg  <= mac_v1_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.neuron      <= 6'(row_emit);
            out_item_reg.activation  <= SIG_TABLE[idx_reg];
            out_item_reg.last_output <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### hdl/dense_sigmoid_layer.sv
`timescale 1ns / 1ps

// dense layer with sigmoid activation
// input channel (in_valid / in_stall / in_item): each transfer is a weight
//   write, a bias write or one input element
// an input element with last_element set starts the forward pass; in_stall
//   stays high until the final result has been loaded into the output register
// per output row: one bias read, the column walk on the single shared
//   multiply-accumulate, a drain of the read and multiply stages, a saturate
//   step and an emit step
// output channel (out_valid / out_stall / out_item): one transfer per row in
//   increasing order, last_output on the final row; a stall holds the output
//   register and the next row waits in the emit step until it frees
// apb port: input_count at 0x0, output_count at 0x4, both reset to 64
// reset clears control state only; weights, biases and inputs read as
//   garbage until written
module dense_sigmoid_layer #(
    parameter int IN_MAX  = dsl_pkg::IN_MAX_DEF,
    parameter int OUT_MAX = dsl_pkg::OUT_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dsl_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output dsl_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dsl_pkg::*;

    localparam int CW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int RW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int CNTW = $clog2(IN_MAX + 1);
    localparam int NOW  = $clog2(OUT_MAX + 1);

    logic [6:0]      input_count_reg;
    logic [6:0]      output_count_reg;
    logic            cfg_wr;
    logic [CNTW-1:0] n_in;
    logic [NOW-1:0]  n_out;
    dsl_cmd_t        cmd;
    dsl_stat_t       stat;
    logic [CW-1:0]   col;
    logic [RW-1:0]   row;

    // register file, written in the access phase; byte lanes ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= COUNT_RESET;
            output_count_reg <= COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_INPUT_COUNT)
            begin
                input_count_reg <= pwdata[6:0];
            end
            else
            begin
                output_count_reg <= pwdata[6:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_OUTPUT_COUNT) ? {25'd0, output_count_reg}
                                                   : {25'd0, input_count_reg};

    // counts clamp to 1..store size
    always_comb
    begin
        if (input_count_reg == 7'd0)
        begin
            n_in = CNTW'(1);
        end
        else if (32'(input_count_reg) > IN_MAX)
        begin
            n_in = CNTW'(IN_MAX);
        end
        else
        begin
            n_in = CNTW'(input_count_reg);
        end
    end

    always_comb
    begin
        if (output_count_reg == 7'd0)
        begin
            n_out = NOW'(1);
        end
        else if (32'(output_count_reg) > OUT_MAX)
        begin
            n_out = NOW'(OUT_MAX);
        end
        else
        begin
            n_out = NOW'(output_count_reg);
        end
    end

    // sequencer: walks rows and columns, drives the datapath
    dsl_ctrl #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .n_in     (n_in),
        .n_out    (n_out),
        .stat     (stat),
        .cmd      (cmd),
        .col      (col),
        .row      (row),
        .in_stall (in_stall)
    );

    // stores, multiply-accumulate, saturation, table and output register
    dsl_datapath #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .col       (col),
        .row       (row),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

### hdl/dsl_checker.sv
`timescale 1ns / 1ps

module dsl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input dsl_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input dsl_pkg::out_item_t out_item
);
    import dsl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // the final input element starts the pass and closes the input side
    a_start_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.mode == MODE_FEED && in_item.last_element
        |=> in_stall)
        else $error("no stall after final input element");

    // any other transfer leaves the block ready
    a_plain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !(in_item.mode == MODE_FEED && in_item.last_element)
        |=> !in_stall)
        else $error("stall after a store transfer");

    // a result that is not the final one means the pass is still running
    a_mid_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last_output |-> in_stall)
        else $error("input side open in the middle of a pass");

endmodule

bind dense_sigmoid_layer dsl_checker u_dsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
